@@ sv/tcbi_pkg.sv @@
`timescale 1ns / 1ps

package tcbi_pkg;

    localparam int TYPES_DEF     = 4;
    localparam int SLOPES_DEF    = 4;
    localparam int CUTOFF_DEF    = 32;
    localparam int CHARACTER_DEF = 8;
    localparam int RESONANCE_DEF = 8;

    localparam int TABLE_DEPTH = 32768;
    localparam int ADDR_W      = 15;
    localparam int IDX_W       = 7;
    localparam int POS_W       = 17;
    localparam int ACC_W       = 28;
    localparam int MUL_B_W     = 18;
    localparam int RND_W       = 30;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [14:0]        table_index;
        logic signed [15:0] table_value;
        logic [16:0]        cutoff_position;
        logic [16:0]        character_position;
        logic [16:0]        resonance_position;
        logic [1:0]         slope_select;
        logic [1:0]         filter_type;
    } t_cmd;

    typedef struct packed {
        logic signed [15:0] level_db;
        logic               is_query_result;
    } t_result;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [POS_W-1:0] frac;
    } t_split;

    typedef enum logic [3:0] {
        S_IDLE, S_SETUP, S_BASE, S_READ, S_MUL, S_ADD, S_GUARD, S_COEF, S_DONE
    } t_state;

    typedef enum logic [2:0] {
        OP_LERP_A, OP_LERP_B, OP_LERP_P, OP_HORNER_3, OP_HORNER_2, OP_HORNER_1
    } t_op;

    // Clamp a Q1.16 position, scale it onto n grid points and split it into
    // a cell index and a Q.16 fraction within that cell.
    function automatic t_split axis_split(logic [POS_W-1:0] pos, logic [7:0] n);
        logic [POS_W-1:0] clamped;
        logic [6:0]       nm1;
        logic [7:0]       lim;
        logic [23:0]      p;
        logic [7:0]       i8;
        logic [23:0]      fr;
        t_split           s;
        clamped = (pos > 17'd65536) ? 17'd65536 : pos;
        nm1     = 7'(n - 8'd1);
        lim     = n - 8'd2;
        p       = 24'(clamped) * 24'(nm1);
        i8      = p[23:16];
        if (i8 > lim) begin
            i8 = lim;
        end
        fr     = p - {i8, 16'd0};
        s.idx  = i8[IDX_W-1:0];
        s.frac = fr[POS_W-1:0];
        return s;
    endfunction

endpackage

@@ sv/tcbi_mul_unit.sv @@
`timescale 1ns / 1ps

module tcbi_mul_unit (
    input  logic                                 i_clk,
    input  logic signed [tcbi_pkg::ACC_W-1:0]    i_a,
    input  logic signed [tcbi_pkg::MUL_B_W-1:0]  i_b,
    output logic signed [tcbi_pkg::RND_W-1:0]    o_rnd
);
    import tcbi_pkg::*;

    localparam int PROD_W = ACC_W + MUL_B_W;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] w_biased;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    // Round half up, then drop the sixteen fraction bits.
    assign w_biased = r_prod + PROD_W'(32768);
    assign o_rnd    = RND_W'(w_biased >>> 16);

endmodule

@@ sv/table_cubic_bilinear_interpolator.sv @@
`timescale 1ns / 1ps
// Write word: the table entry is stored at the accepting edge, the
// acknowledge is on the result ports in the next cycle, and busy stays low.
// Query word: four cutoff planes are read, or three at either end of the table. Each plane
// takes four reads from the single table port and three multiplier passes; busy is high
// until the strobe cycle. Reset clears only the sequencer and the strobe.
module table_cubic_bilinear_interpolator #(
    parameter int NUM_TYPES     = tcbi_pkg::TYPES_DEF,
    parameter int NUM_SLOPES    = tcbi_pkg::SLOPES_DEF,
    parameter int NUM_CUTOFF    = tcbi_pkg::CUTOFF_DEF,
    parameter int NUM_CHARACTER = tcbi_pkg::CHARACTER_DEF,
    parameter int NUM_RESONANCE = tcbi_pkg::RESONANCE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  tcbi_pkg::t_cmd    i_cmd,
    output logic              o_result_strobe,
    output tcbi_pkg::t_result o_result
);
    import tcbi_pkg::*;

    // Address strides are taken modulo the table depth, like every read address.
    localparam logic [ADDR_W-1:0] STRIDE_R     = ADDR_W'(NUM_RESONANCE);
    localparam logic [ADDR_W-1:0] STRIDE_PLANE = ADDR_W'(NUM_CHARACTER * NUM_RESONANCE);
    localparam logic [ADDR_W-1:0] MUL_CUT      = ADDR_W'(NUM_CUTOFF);
    localparam logic [ADDR_W-1:0] MUL_CHAR     = ADDR_W'(NUM_CHARACTER);
    localparam logic [ADDR_W-1:0] MUL_SLOPES   = ADDR_W'(NUM_SLOPES);
    localparam logic [IDX_W-1:0]  LAST_CELL    = IDX_W'(NUM_CUTOFF - 2);

    // The table itself: a registered read every cycle, plus a write when a write word is taken.
    logic signed [15:0] r_mem [TABLE_DEPTH];
    logic signed [15:0] r_rd;
    logic [ADDR_W-1:0]  w_rd_addr;

    t_state r_state, n_state;
    t_op    r_op;
    t_cmd   r_cmd;

    logic [IDX_W-1:0] r_iu, r_ic, r_ir;
    logic [POS_W-1:0] r_tu, r_tc, r_tr;
    logic [ADDR_W-1:0] r_base;
    logic [ADDR_W-1:0] r_pb;
    logic [2:0]        r_j;
    logic [1:0]        r_k, r_khi;

    logic signed [15:0] r_e [4];
    logic signed [15:0] r_la, r_lb;
    logic signed [17:0] r_p [4];
    logic signed [ACC_W-1:0] r_c0, r_c1, r_c2, r_c3, r_acc;

    logic signed [ACC_W-1:0]   w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic signed [RND_W-1:0]   w_rnd;
    logic signed [RND_W-1:0]   w_addend;
    logic signed [RND_W-1:0]   w_sum;
    logic signed [ACC_W-1:0]   w_half;

    logic w_accept, w_wr;
    logic r_strobe;
    t_result r_result;

    logic [2:0] w_sl, w_ty;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_wr     = w_accept && (i_cmd.mode == MODE_WRITE);

    // Out-of-range selectors fall back to the last available slope or type.
    assign w_sl = (3'(r_cmd.slope_select) > 3'(NUM_SLOPES - 1)) ?
                  3'(NUM_SLOPES - 1) : 3'(r_cmd.slope_select);
    assign w_ty = (3'(r_cmd.filter_type) > 3'(NUM_TYPES - 1)) ?
                  3'(NUM_TYPES - 1) : 3'(r_cmd.filter_type);

    // Read offsets within one plane cell: (c,r), (c+1,r), (c,r+1), (c+1,r+1).
    always_comb begin
        case (r_j[1:0])
            2'd0:    w_rd_addr = r_pb;
            2'd1:    w_rd_addr = r_pb + STRIDE_R;
            2'd2:    w_rd_addr = r_pb + ADDR_W'(1);
            default: w_rd_addr = r_pb + STRIDE_R + ADDR_W'(1);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[i_cmd.table_index] <= i_cmd.table_value;
        end
        r_rd <= r_mem[w_rd_addr];
    end

    // Operand selection for the shared multiplier and the addend that follows it.
    always_comb begin
        w_mul_a  = '0;
        w_mul_b  = '0;
        w_addend = '0;
        case (r_op)
            OP_LERP_A: begin
                w_mul_a  = ACC_W'(r_e[1]) - ACC_W'(r_e[0]);
                w_mul_b  = MUL_B_W'(r_tc);
                w_addend = RND_W'(r_e[0]);
            end
            OP_LERP_B: begin
                w_mul_a  = ACC_W'(r_e[3]) - ACC_W'(r_e[2]);
                w_mul_b  = MUL_B_W'(r_tc);
                w_addend = RND_W'(r_e[2]);
            end
            OP_LERP_P: begin
                w_mul_a  = ACC_W'(r_lb) - ACC_W'(r_la);
                w_mul_b  = MUL_B_W'(r_tr);
                w_addend = RND_W'(r_la);
            end
            OP_HORNER_3: begin
                w_mul_a  = r_c3;
                w_mul_b  = MUL_B_W'(r_tu);
                w_addend = RND_W'(r_c2);
            end
            OP_HORNER_2: begin
                w_mul_a  = r_acc;
                w_mul_b  = MUL_B_W'(r_tu);
                w_addend = RND_W'(r_c1);
            end
            default: begin
                w_mul_a  = r_acc;
                w_mul_b  = MUL_B_W'(r_tu);
                w_addend = RND_W'(r_c0);
            end
        endcase
    end

    tcbi_mul_unit u_mul (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_rnd (w_rnd)
    );

    assign w_sum  = w_addend + w_rnd;
    assign w_half = (r_acc + ACC_W'(1)) >>> 1;

    // Sequencer: setup, per-plane reads and blends, guard planes, spline, result.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_cmd.mode == MODE_QUERY)) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: n_state = S_BASE;
            S_BASE:  n_state = S_READ;
            S_READ: begin
                if (r_j == 3'd4) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: n_state = S_ADD;
            S_ADD: begin
                if (r_op == OP_LERP_P) begin
                    n_state = (r_k == r_khi) ? S_GUARD : S_READ;
                end else if (r_op == OP_HORNER_1) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_GUARD: n_state = S_COEF;
            S_COEF:  n_state = S_MUL;
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        t_split su, sc, sr;
        su = axis_split(r_cmd.cutoff_position, 8'(NUM_CUTOFF));
        sc = axis_split(r_cmd.character_position, 8'(NUM_CHARACTER));
        sr = axis_split(r_cmd.resonance_position, 8'(NUM_RESONANCE));
        if (w_accept) begin
            r_cmd <= i_cmd;
        end
        case (r_state)
            S_SETUP: begin
                r_iu   <= su.idx;
                r_tu   <= su.frac;
                r_ic   <= sc.idx;
                r_tc   <= sc.frac;
                r_ir   <= sr.idx;
                r_tr   <= sr.frac;
                r_base <= ADDR_W'(w_ty) * MUL_SLOPES + ADDR_W'(w_sl);
            end
            S_BASE: begin
                // Planes below the table or above it are not read; they are
                // extrapolated from the two nearest planes afterwards.
                r_k   <= (r_iu == '0) ? 2'd1 : 2'd0;
                r_khi <= (r_iu == LAST_CELL) ? 2'd2 : 2'd3;
                r_j   <= '0;
                r_pb  <= (((r_base * MUL_CUT + ADDR_W'((r_iu == '0) ? r_iu : r_iu - 1'b1))
                          * MUL_CHAR + ADDR_W'(r_ic)) * STRIDE_R) + ADDR_W'(r_ir);
            end
            S_READ: begin
                if (r_j != 3'd0) begin
                    r_e[r_j[1:0] - 2'd1] <= r_rd;
                end
                r_j  <= r_j + 3'd1;
                r_op <= OP_LERP_A;
            end
            S_ADD: begin
                case (r_op)
                    OP_LERP_A: begin
                        r_la <= 16'(w_sum);
                        r_op <= OP_LERP_B;
                    end
                    OP_LERP_B: begin
                        r_lb <= 16'(w_sum);
                        r_op <= OP_LERP_P;
                    end
                    OP_LERP_P: begin
                        r_p[r_k] <= 18'(w_sum);
                        r_k      <= r_k + 2'd1;
                        r_j      <= '0;
                        r_pb     <= r_pb + STRIDE_PLANE;
                        r_op     <= OP_LERP_A;
                    end
                    OP_HORNER_3: begin
                        r_acc <= ACC_W'(w_sum);
                        r_op  <= OP_HORNER_2;
                    end
                    OP_HORNER_2: begin
                        r_acc <= ACC_W'(w_sum);
                        r_op  <= OP_HORNER_1;
                    end
                    default: begin
                        r_acc <= ACC_W'(w_sum);
                    end
                endcase
            end
            S_GUARD: begin
                if (r_iu == '0) begin
                    r_p[0] <= (r_p[1] <<< 1) - r_p[2];
                end
                if (r_iu == LAST_CELL) begin
                    r_p[3] <= (r_p[2] <<< 1) - r_p[1];
                end
            end
            S_COEF: begin
                r_c0 <= ACC_W'(r_p[1]) <<< 1;
                r_c1 <= ACC_W'(r_p[2]) - ACC_W'(r_p[0]);
                r_c2 <= (ACC_W'(r_p[0]) <<< 1) - ((ACC_W'(r_p[1]) <<< 2) + ACC_W'(r_p[1]))
                        + (ACC_W'(r_p[2]) <<< 2) - ACC_W'(r_p[3]);
                r_c3 <= ACC_W'(r_p[3]) - ACC_W'(r_p[0])
                        + ((ACC_W'(r_p[1]) - ACC_W'(r_p[2])) * ACC_W'(3));
                r_op <= OP_HORNER_3;
            end
            default: ;
        endcase
    end

    // Result register: a write acknowledge or the saturated query answer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_wr || (r_state == S_DONE);
        end
        if (r_state == S_DONE) begin
            r_result.is_query_result <= 1'b1;
            if (w_half > ACC_W'(32767)) begin
                r_result.level_db <= 16'sh7FFF;
            end else if (w_half < -ACC_W'(32768)) begin
                r_result.level_db <= 16'sh8000;
            end else begin
                r_result.level_db <= 16'(w_half);
            end
        end else if (w_wr) begin
            r_result.is_query_result <= 1'b0;
            r_result.level_db        <= '0;
        end
    end

    assign o_result_strobe = r_strobe;
    assign o_result        = r_result;

    a_write_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr |=> (o_result_strobe && !o_result.is_query_result))
        else $error("write word was not acknowledged");

    a_query_ans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> (o_result_strobe && o_result.is_query_result && !busy))
        else $error("query answer missing after sequence end");

    a_plane_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (r_k <= r_khi))
        else $error("plane counter ran past the last plane");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_result_strobe && !busy))
        else $error("strobe or busy set right after reset");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import tcbi_pkg::*;

    localparam int NT = TYPES_DEF;
    localparam int NS = SLOPES_DEF;
    localparam int NU = CUTOFF_DEF;
    localparam int NC = CHARACTER_DEF;
    localparam int NR = RESONANCE_DEF;
    localparam int PLANE_SIZE = NC * NR;
    localparam int BASE_SIZE  = NU * PLANE_SIZE;
    localparam int USED_DEPTH = NT * NS * BASE_SIZE;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    t_cmd    i_cmd;
    logic    o_result_strobe;
    t_result o_result;

    int error_count;

    table_cubic_bilinear_interpolator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .o_result_strobe(o_result_strobe),
        .o_result       (o_result)
    );

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Predicts each word's result from a private copy of the level table and
    // keeps the expectations in arrival order.
    class level_scoreboard;
        logic signed [15:0] levels [USED_DEPTH];
        bit                 written [USED_DEPTH];
        t_result            pending [$];

        function automatic longint rnd(longint v, int k);
            longint half;
            half = longint'(1) << (k - 1);
            if (v >= 0) return (v + half) >>> k;
            return -((-v + half - 1) >>> k);
        endfunction

        function automatic longint lerp(longint a, longint b, longint t);
            return a + rnd((b - a) * t, 16);
        endfunction

        function automatic void split(logic [16:0] pos, int n, output int idx,
                                      output longint frac);
            longint p;
            p = (pos > 17'd65536 ? 65536 : pos) * (n - 1);
            idx = int'(p >> 16);
            if (idx > n - 2) idx = n - 2;
            frac = p - (longint'(idx) << 16);
        endfunction

        function automatic longint plane_level(int base, int u, int c, int r,
                                               longint tc, longint tr);
            int a;
            longint x, y;
            a = ((base * NU + u) * NC + c) * NR + r;
            x = lerp(levels[a], levels[a + NR], tc);
            y = lerp(levels[a + 1], levels[a + NR + 1], tc);
            return lerp(x, y, tr);
        endfunction

        function automatic longint guarded(int base, int u, int c, int r,
                                           longint tc, longint tr);
            if (u < 0)
                return 2 * plane_level(base, 0, c, r, tc, tr) - plane_level(base, 1, c, r, tc, tr);
            if (u > NU - 1)
                return 2 * plane_level(base, NU - 1, c, r, tc, tr)
                       - plane_level(base, NU - 2, c, r, tc, tr);
            return plane_level(base, u, c, r, tc, tr);
        endfunction

        function automatic void note_word(t_cmd w);
            t_result e;
            int sl, ty, base, iu, ic, ir;
            longint tu, tc, tr, p0, p1, p2, p3, s;
            if (w.mode == MODE_WRITE) begin
                if (w.table_index < USED_DEPTH) begin
                    levels[w.table_index] = w.table_value;
                    written[w.table_index] = 1'b1;
                end
                e.level_db = '0;
                e.is_query_result = 1'b0;
            end else begin
                sl = (w.slope_select > NS - 1) ? NS - 1 : w.slope_select;
                ty = (w.filter_type > NT - 1) ? NT - 1 : w.filter_type;
                base = ty * NS + sl;
                split(w.cutoff_position, NU, iu, tu);
                split(w.character_position, NC, ic, tc);
                split(w.resonance_position, NR, ir, tr);
                p0 = guarded(base, iu - 1, ic, ir, tc, tr);
                p1 = guarded(base, iu, ic, ir, tc, tr);
                p2 = guarded(base, iu + 1, ic, ir, tc, tr);
                p3 = guarded(base, iu + 2, ic, ir, tc, tr);
                s = rnd((-p0 + 3 * p1 - 3 * p2 + p3) * tu, 16) + (2 * p0 - 5 * p1 + 4 * p2 - p3);
                s = rnd(s * tu, 16) + (p2 - p0);
                s = rnd(s * tu, 16) + 2 * p1;
                s = rnd(s, 1);
                if (s > 32767) s = 32767;
                if (s < -32768) s = -32768;
                e.level_db = 16'(s);
                e.is_query_result = 1'b1;
            end
            pending.push_back(e);
        endfunction

        task automatic check_result(t_result got);
            t_result e;
            if (pending.size() == 0) begin
                report_mismatch("unexpected result word", got.level_db, 0);
                return;
            end
            e = pending.pop_front();
            if (got.is_query_result !== e.is_query_result)
                report_mismatch("is_query_result", got.is_query_result, e.is_query_result);
            if (got.level_db !== e.level_db)
                report_mismatch("level_db", got.level_db, e.level_db);
        endtask
    endclass

    level_scoreboard board;
    int idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard limit on the run; the slowest correct run is far below this.
    initial begin
        #50ms;
        $display("Some tests failed");
        $finish;
    end

    // Results cannot be held off, so every strobe is checked at its edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_strobe === 1'b1) board.check_result(o_result);
    end

    // Presents one word after a random idle gap and holds it until the edge
    // where busy is low. Start stays high between back-to-back words.
    task automatic send_word(input t_cmd w);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= w;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        board.note_word(w);
        @(negedge i_clk);
    endtask

    task automatic send_write(input int idx, input logic signed [15:0] v);
        t_cmd w;
        w = t_cmd'({$urandom, $urandom, $urandom});
        w.mode = MODE_WRITE;
        w.table_index = idx[14:0];
        w.table_value = v;
        send_word(w);
    endtask

    // Positions mostly in range, sometimes at the ends or beyond 1.0.
    function automatic logic [16:0] pick_position();
        case ($urandom_range(7))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'($urandom_range(131071, 65537));
            default: return 17'($urandom_range(65535));
        endcase
    endfunction

    function automatic logic signed [15:0] pick_level();
        case ($urandom_range(5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'($urandom);
            default: return 16'($signed($urandom_range(4000)) - 2000);
        endcase
    endfunction

    // Position inside the first cell of an axis with n points, or anywhere from
    // the last cell up to beyond 1.0.
    function automatic logic [16:0] corner_position(int n, bit high);
        if (high) return 17'($urandom_range(131071, (65536 * (n - 2)) / (n - 1) + 1));
        return 17'($urandom_range(65536 / (n - 1) - 1));
    endfunction

    // Writes every entry that a query will read and that holds no level yet,
    // so that no query ever reads an unwritten entry.
    task automatic fill_for(input t_cmd w);
        int sl, ty, base, iu, ic, ir, a, ulo, uhi;
        longint tu, tc, tr;
        sl = (w.slope_select > NS - 1) ? NS - 1 : w.slope_select;
        ty = (w.filter_type > NT - 1) ? NT - 1 : w.filter_type;
        base = ty * NS + sl;
        board.split(w.cutoff_position, NU, iu, tu);
        board.split(w.character_position, NC, ic, tc);
        board.split(w.resonance_position, NR, ir, tr);
        ulo = (iu > 0) ? iu - 1 : 0;
        uhi = (iu + 2 < NU) ? iu + 2 : NU - 1;
        for (int u = ulo; u <= uhi; u++)
            for (int c = ic; c <= ic + 1; c++)
                for (int r = ir; r <= ir + 1; r++) begin
                    a = ((base * NU + u) * NC + c) * NR + r;
                    if (!board.written[a]) send_write(a, pick_level());
                end
    endtask

    task automatic send_query(input logic [16:0] cu, input logic [16:0] ch,
                              input logic [16:0] rs, input logic [1:0] sl,
                              input logic [1:0] ty);
        t_cmd w;
        w = t_cmd'({$urandom, $urandom, $urandom});
        w.mode = MODE_QUERY;
        w.cutoff_position = cu;
        w.character_position = ch;
        w.resonance_position = rs;
        w.slope_select = sl;
        w.filter_type = ty;
        fill_for(w);
        send_word(w);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (board.pending.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        int n;
        bit hi;
        logic [1:0] sel;
        error_count = 0;
        board = new();
        idle_pct = 0;
        start = 1'b0;
        i_cmd = '0;
        i_rst_n = 1'b0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed words: corners of every axis, selector ends, over-range positions.
        send_query(17'd0, 17'd0, 17'd0, 2'd0, 2'd0);
        send_query(17'd65536, 17'd65536, 17'd65536, 2'd3, 2'd3);
        send_query(17'h1ffff, 17'h1ffff, 17'h1ffff, 2'd3, 2'd0);
        send_query(17'd1024, 17'd32768, 17'd65535, 2'd1, 2'd2);
        send_query(17'd65000, 17'd1, 17'd40000, 2'd2, 2'd1);
        send_query(17'h0ffff, 17'h10000, 17'h0aaaa, 2'd0, 2'd3);
        send_write(0, 16'sh7fff);
        send_write(1, 16'sh8000);
        send_write(32767, 16'sh1234);
        send_query(17'd0, 17'd0, 17'd0, 2'd0, 2'd0);
        send_query(17'd2000, 17'd9000, 17'd9000, 2'd0, 2'd0);
        // Drive a cutoff edge to extremes so the spline saturates.
        for (int c = 0; c < 3; c++)
            for (int k = 0; k < PLANE_SIZE; k++)
                send_write(c * PLANE_SIZE + k, (c == 1) ? 16'sh7fff : 16'sh8000);
        send_query(17'd2100, 17'd30000, 17'd30000, 2'd0, 2'd0);
        send_query(17'd3000, 17'd0, 17'd65536, 2'd0, 2'd0);

        // Sender pauses until everything has come back.
        wait_drained();

        // Random queries keep character and resonance in the corner cells of two
        // selector pairs so the entries they need are loaded once and then reused.
        for (int phase = 0; phase < 4; phase++) begin
            idle_pct = (phase == 1 || phase == 2) ? 65 : (phase == 3 ? 25 : 0);
            for (n = 0; n < 120; n++) begin
                hi = 1'($urandom_range(1));
                sel = ($urandom_range(1) == 0) ? 2'd0 : 2'd3;
                if ($urandom_range(3) == 0)
                    send_write($urandom_range(32767), pick_level());
                else
                    send_query(pick_position(), corner_position(NC, hi),
                               corner_position(NR, hi), sel, sel);
            end
        end

        wait_drained();
        repeat (80) @(negedge i_clk);
        if (error_count == 0 && board.pending.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
